// ===== rtl/core/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// shared constants, types and codes of the column heads-and-tails transform
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 4096;

  localparam int SAMPLE_W   = 32;
  localparam int VALUE_W    = 48;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROWCNT_W   = ROW_W + 1;
  localparam int COLCNT_W   = COL_W + 1;
  localparam int SUM_W      = 48;
  localparam int XK_W       = SAMPLE_W + ROW_W + 1;
  localparam int NUM_W      = SUM_W + 1;
  localparam int DIV_W      = 2 * ROW_W;
  localparam int ROOT_W     = 31;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int DIV_STEPS  = SQ_W + 1;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int MUL_A_W    = 32;
  localparam int PROD_W     = MUL_A_W + ROOT_W;
  localparam int HI_W       = NUM_W - MUL_A_W;
  localparam int PHI_W      = HI_W + ROOT_W;
  localparam int Q_W        = PHI_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROWCNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

  localparam logic [ROWCNT_W-1:0] ROWS_MIN = ROWCNT_W'(2);
  localparam logic [ROWCNT_W-1:0] ROWS_MAX = ROWCNT_W'(MAX_ROWS);
  localparam logic [COLCNT_W-1:0] COLS_MIN = COLCNT_W'(1);
  localparam logic [COLCNT_W-1:0] COLS_MAX = COLCNT_W'(MAX_COLUMNS);

  localparam logic [Q_W-1:0] Q_POS_LIMIT = Q_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
  localparam logic [Q_W-1:0] Q_NEG_LIMIT = Q_W'(64'd1 << (VALUE_W - 1));
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(64'd1 << (ROOT_W - 1));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP_TAIL,
    ST_SETUP_HEAD,
    ST_DIV,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMBINE,
    ST_EMIT
  } cht_state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic setup_tail;
    logic setup_head;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic mul_lo;
    logic mul_hi;
    logic combine;
    logic emit;
  } cht_cmd_t;

  typedef struct packed {
    logic row_zero;
    logic last_row;
    logic head_phase;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } cht_stat_t;

endpackage

// ===== rtl/core/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// sequencer: load, reciprocal root (divide then square root), scale, emit
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cht_pkg::cht_stat_t stat_i,
  output logic              in_ready_o,
  output cht_pkg::cht_cmd_t cmd_o
);

  cht_pkg::cht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cht_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = cht_pkg::ST_LOAD;
        end
      end
      cht_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = stat_i.row_zero ? cht_pkg::ST_IDLE : cht_pkg::ST_SETUP_TAIL;
      end
      cht_pkg::ST_SETUP_TAIL: begin
        cmd_o.setup_tail = 1'b1;
        state_d          = cht_pkg::ST_DIV;
      end
      cht_pkg::ST_SETUP_HEAD: begin
        cmd_o.setup_head = 1'b1;
        state_d          = cht_pkg::ST_DIV;
      end
      cht_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = cht_pkg::ST_SQRT_INIT;
        end
      end
      cht_pkg::ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = cht_pkg::ST_SQRT;
      end
      cht_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_done) begin
          state_d = cht_pkg::ST_MUL_LO;
        end
      end
      cht_pkg::ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = cht_pkg::ST_MUL_HI;
      end
      cht_pkg::ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = cht_pkg::ST_COMBINE;
      end
      cht_pkg::ST_COMBINE: begin
        cmd_o.combine = 1'b1;
        state_d       = cht_pkg::ST_EMIT;
      end
      cht_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!stat_i.head_phase && stat_i.last_row) begin
            state_d = cht_pkg::ST_SETUP_HEAD;
          end else begin
            state_d = cht_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cht_datapath.sv =====
// ----------------------------------------------------------------------------
// cht_datapath
// position counters, column sum ram, radix-2 divider, square root unit,
// shared multiplier, rounding, saturation and output register
// ----------------------------------------------------------------------------
module cht_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cht_pkg::cht_cmd_t                 cmd_i,
  output cht_pkg::cht_stat_t                stat_o,
  input  logic                              cfg_valid_i,
  input  logic [cht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [cht_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [cht_pkg::VALUE_W-1:0] result_value_o,
  output logic [cht_pkg::ROW_W-1:0]         row_index_o,
  output logic [cht_pkg::COL_W-1:0]         column_index_o,
  output logic                              is_head_o,
  output logic                              last_of_run_o,
  output logic                              saturated_o
);

  // configuration and position
  logic [cht_pkg::ROWCNT_W-1:0] rows_cfg_q;
  logic [cht_pkg::COLCNT_W-1:0] cols_cfg_q;
  logic [cht_pkg::ROWCNT_W-1:0] rows_eff;
  logic [cht_pkg::COLCNT_W-1:0] cols_eff;
  logic [cht_pkg::ROW_W-1:0]    pos_row_q;
  logic [cht_pkg::COL_W-1:0]    pos_col_q;
  logic [cht_pkg::ROWCNT_W-1:0] row_next;
  logic [cht_pkg::COLCNT_W-1:0] col_next;
  logic                         cfg_hit;

  // item registers
  logic signed [cht_pkg::SAMPLE_W-1:0] x_q;
  logic [cht_pkg::ROW_W-1:0]           row_q;
  logic [cht_pkg::COL_W-1:0]           col_q;
  logic                                last_row_q;
  logic                                head_phase_q;

  // sums
  logic [cht_pkg::SUM_W-1:0]        ram_rdata;
  logic [cht_pkg::SUM_W-1:0]        ram_wdata;
  logic signed [cht_pkg::SUM_W-1:0] x_ext;
  logic signed [cht_pkg::SUM_W-1:0] new_sum;
  logic signed [cht_pkg::SUM_W-1:0] prior_q;
  logic signed [cht_pkg::SUM_W-1:0] head_num_q;
  logic signed [cht_pkg::XK_W-1:0]  xk_d;
  logic signed [cht_pkg::XK_W-1:0]  xk_q;
  logic [cht_pkg::ROW_W:0]          row_inc;
  logic [2*cht_pkg::ROW_W:0]        km_full;
  logic [cht_pkg::DIV_W-1:0]        km_q;

  // reciprocal root
  logic signed [cht_pkg::NUM_W-1:0] num_q;
  logic [cht_pkg::DIV_W-1:0]        m_q;
  logic [cht_pkg::DIV_W-1:0]        rem_q;
  logic [cht_pkg::DIV_W:0]          rem_sh;
  logic                             div_ge;
  logic [cht_pkg::SQ_W-1:0]         quo_q;
  logic [cht_pkg::CNT_W-1:0]        cnt_q;
  logic [cht_pkg::SQ_W-1:0]         n_q;
  logic [cht_pkg::SQ_W-1:0]         r_q;
  logic [cht_pkg::SQ_W-1:0]         bit_q;
  logic [cht_pkg::SQ_W-1:0]         sq_trial;

  // scaling
  logic [cht_pkg::NUM_W-1:0]   mag_q;
  logic                        neg_q;
  logic [cht_pkg::MUL_A_W-1:0] mul_a;
  logic [cht_pkg::PROD_W-1:0]  prod;
  logic [cht_pkg::PROD_W-1:0]  plo_q;
  logic [cht_pkg::PHI_W-1:0]   phi_q;
  logic [cht_pkg::PROD_W:0]    lo_round;
  logic [cht_pkg::Q_W-1:0]     qsum_q;
  logic                        sat_pos;
  logic                        sat_neg;
  logic [cht_pkg::VALUE_W-1:0] value_d;

  // output register
  logic                        out_valid_q;
  logic [cht_pkg::VALUE_W-1:0] value_q;
  logic [cht_pkg::ROW_W-1:0]   out_row_q;
  logic [cht_pkg::COL_W-1:0]   out_col_q;
  logic                        out_head_q;
  logic                        out_last_q;
  logic                        out_sat_q;

  always_comb begin
    rows_eff = rows_cfg_q;
    if (rows_cfg_q < cht_pkg::ROWS_MIN) begin
      rows_eff = cht_pkg::ROWS_MIN;
    end else if (rows_cfg_q > cht_pkg::ROWS_MAX) begin
      rows_eff = cht_pkg::ROWS_MAX;
    end
    cols_eff = cols_cfg_q;
    if (cols_cfg_q < cht_pkg::COLS_MIN) begin
      cols_eff = cht_pkg::COLS_MIN;
    end else if (cols_cfg_q > cht_pkg::COLS_MAX) begin
      cols_eff = cht_pkg::COLS_MAX;
    end
  end

  assign row_next = {1'b0, pos_row_q} + 1'b1;
  assign col_next = {1'b0, pos_col_q} + 1'b1;
  assign cfg_hit  = cfg_valid_i &&
                    (cfg_index_i == cht_pkg::CFG_ROW_COUNT ||
                     cfg_index_i == cht_pkg::CFG_COLUMN_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= cht_pkg::ROWS_MIN;
      cols_cfg_q <= cht_pkg::COLS_MIN;
      pos_row_q  <= '0;
      pos_col_q  <= '0;
    end else begin
      if (cfg_hit) begin
        if (cfg_index_i == cht_pkg::CFG_ROW_COUNT) begin
          rows_cfg_q <= cfg_data_i[cht_pkg::ROWCNT_W-1:0];
        end else begin
          cols_cfg_q <= cfg_data_i[cht_pkg::COLCNT_W-1:0];
        end
        pos_row_q <= '0;
        pos_col_q <= '0;
      end else if (cmd_i.accept) begin
        if (col_next >= cols_eff) begin
          pos_col_q <= '0;
          if (row_next >= rows_eff) begin
            pos_row_q <= '0;
          end else begin
            pos_row_q <= row_next[cht_pkg::ROW_W-1:0];
          end
        end else begin
          pos_col_q <= col_next[cht_pkg::COL_W-1:0];
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q        <= sample_i;
      row_q      <= pos_row_q;
      col_q      <= pos_col_q;
      last_row_q <= ({1'b0, pos_row_q} == rows_eff - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_phase_q <= 1'b0;
    end else if (cmd_i.setup_head) begin
      head_phase_q <= 1'b1;
    end else if (cmd_i.setup_tail) begin
      head_phase_q <= 1'b0;
    end
  end

  // column sums: read at accept, read-modify-write in the load cycle
  assign x_ext     = cht_pkg::SUM_W'(x_q);
  assign new_sum   = $signed(ram_rdata) + x_ext;
  assign ram_wdata = (row_q == '0) ? x_ext : new_sum;

  cht_ram #(
    .WIDTH (cht_pkg::SUM_W),
    .DEPTH (cht_pkg::MAX_COLUMNS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .raddr_i (pos_col_q),
    .rdata_o (ram_rdata)
  );

  assign xk_d    = x_q * $signed({1'b0, row_q});
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign km_full = row_q * row_inc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prior_q    <= $signed(ram_rdata);
      head_num_q <= new_sum;
      xk_q       <= xk_d;
      km_q       <= km_full[cht_pkg::DIV_W-1:0];
    end
  end

  // divider: floor(2^62 / m), one quotient bit a cycle
  assign rem_sh = {rem_q, (cnt_q == '0)};
  assign div_ge = rem_sh >= {1'b0, m_q};

  // square root of the quotient, one root bit a cycle
  assign sq_trial = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_tail || cmd_i.setup_head) begin
      if (cmd_i.setup_tail) begin
        num_q <= cht_pkg::NUM_W'(xk_q) - cht_pkg::NUM_W'(prior_q);
        m_q   <= km_q;
      end else begin
        num_q <= cht_pkg::NUM_W'(head_num_q);
        m_q   <= cht_pkg::DIV_W'(rows_eff);
      end
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= cht_pkg::DIV_W'(div_ge ? (rem_sh - {1'b0, m_q}) : rem_sh);
      quo_q <= {quo_q[cht_pkg::SQ_W-2:0], div_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.sqrt_init) begin
      n_q   <= quo_q;
      r_q   <= '0;
      bit_q <= cht_pkg::SQ_W'(1) << (cht_pkg::SQ_W - 2);
      neg_q <= num_q[cht_pkg::NUM_W-1];
      mag_q <= num_q[cht_pkg::NUM_W-1] ? (~num_q + 1'b1) : num_q;
    end else if (cmd_i.sqrt_step) begin
      if (n_q >= sq_trial) begin
        n_q <= n_q - sq_trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // shared multiplier: low word then high word of the magnitude
  assign mul_a = cmd_i.mul_hi ? cht_pkg::MUL_A_W'(mag_q[cht_pkg::NUM_W-1:cht_pkg::MUL_A_W])
                              : mag_q[cht_pkg::MUL_A_W-1:0];
  assign prod  = mul_a * r_q[cht_pkg::ROOT_W-1:0];

  assign lo_round = {1'b0, plo_q} + cht_pkg::ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      plo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= prod[cht_pkg::PHI_W-1:0];
    end
    if (cmd_i.combine) begin
      qsum_q <= cht_pkg::Q_W'({phi_q, 1'b0}) +
                cht_pkg::Q_W'(lo_round[cht_pkg::PROD_W:cht_pkg::ROOT_W]);
    end
  end

  // rounding sign and saturation
  assign sat_pos = !neg_q && (qsum_q > cht_pkg::Q_POS_LIMIT);
  assign sat_neg = neg_q && (qsum_q > cht_pkg::Q_NEG_LIMIT);

  always_comb begin
    priority if (sat_pos) begin
      value_d = cht_pkg::VALUE_MAX;
    end else if (sat_neg) begin
      value_d = cht_pkg::VALUE_MIN;
    end else if (neg_q) begin
      value_d = ~qsum_q[cht_pkg::VALUE_W-1:0] + 1'b1;
    end else begin
      value_d = qsum_q[cht_pkg::VALUE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      value_q    <= value_d;
      out_row_q  <= head_phase_q ? '0 : row_q;
      out_col_q  <= col_q;
      out_head_q <= head_phase_q;
      out_last_q <= head_phase_q || !last_row_q;
      out_sat_q  <= sat_pos || sat_neg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(value_q);
  assign row_index_o    = out_row_q;
  assign column_index_o = out_col_q;
  assign is_head_o      = out_head_q;
  assign last_of_run_o  = out_last_q;
  assign saturated_o    = out_sat_q;

  assign stat_o.row_zero   = (row_q == '0);
  assign stat_o.last_row   = last_row_q;
  assign stat_o.head_phase = head_phase_q;
  assign stat_o.div_done   = (cnt_q == cht_pkg::CNT_W'(cht_pkg::DIV_STEPS - 1));
  assign stat_o.sqrt_done  = bit_q[0];
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/column_heads_tails_transform_core.sv =====
// row 0 item: accept, then load, then back to idle for the next item; no result
// later rows: one tail result per item, through setup, divide, square root, scale and emit
// last row: the head follows its tail after a second divide, square root and scale
// the reciprocal root uses a 63-step divider and a 31-step square root
// reset: async active low, clears sequencer, position and output valid,
// row_count to 2, column_count to 1; the column sum ram is not cleared
// ----------------------------------------------------------------------------
// column_heads_tails_transform_core
// streamed per-column heads-and-tails transform, q15.16 in, q31.16 out
// ----------------------------------------------------------------------------
module column_heads_tails_transform_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cht_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [cht_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cht_pkg::VALUE_W-1:0]   result_value_o,
  output logic [cht_pkg::ROW_W-1:0]            row_index_o,
  output logic [cht_pkg::COL_W-1:0]            column_index_o,
  output logic                                 is_head_o,
  output logic                                 last_of_run_o,
  output logic                                 saturated_o
);

  cht_pkg::cht_cmd_t  cmd;
  cht_pkg::cht_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  cht_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .is_head_o      (is_head_o),
    .last_of_run_o  (last_of_run_o),
    .saturated_o    (saturated_o)
  );

endmodule
